// File: hw/rtl/pptos_pkg.sv
// Package for the point-to-screen projection pipeline.
// Holds widths, register indices and the divider stage types; no dependencies.
package pptos_pkg;

	localparam int CoefW   = 32;
	localparam int SumW    = 50;
	localparam int MagW    = 51;
	localparam int DivW    = 50;
	localparam int HalfW   = 15;
	localparam int NumW    = 67;
	localparam int QuoW    = 17;
	localparam int LoW     = 26;
	localparam int NumRegs = 7;

	localparam logic [2:0] REG_X_AB = 3'd0;
	localparam logic [2:0] REG_X_CD = 3'd1;
	localparam logic [2:0] REG_Y_AB = 3'd2;
	localparam logic [2:0] REG_Y_CD = 3'd3;
	localparam logic [2:0] REG_W_AB = 3'd4;
	localparam logic [2:0] REG_W_CD = 3'd5;
	localparam logic [2:0] REG_VIEW = 3'd6;

	typedef struct packed {
		logic [NumW-1:0] rem;
		logic [QuoW-1:0] quo;
		logic            neg;
		logic            zero;
		logic            sat;
	} coord_t;

	typedef struct packed {
		logic            vld;
		logic            wzero;
		logic [DivW-1:0] b;
		coord_t          cx;
		coord_t          cy;
	} div_t;

endpackage

// File: hw/rtl/point_project_to_screen_top.sv
// Top level of the point-to-screen projection pipeline.
// Depends on pptos_pkg for widths and divider stage types.
//
// channel  | handshake              | payload
// ---------+------------------------+-------------------------------
// input    | start, busy            | point_x, point_y, point_z
// result   | done (one-cycle pulse) | screen_x, screen_y, invalid
// config   | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// One item per cycle; each result is registered at the output after the last divider stage.
// The depth is set by the 17-step restoring divider, one quotient bit per stage.
// arst_n clears all valid bits and the configuration registers.
// busy stays low: the pipeline never stalls, the receiver takes every result.
module point_project_to_screen_top
	import pptos_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] point_x,
	input  logic [31:0] point_y,
	input  logic [31:0] point_z,
	output logic        done,
	output logic [15:0] screen_x,
	output logic [15:0] screen_y,
	output logic        invalid,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] regs_q [NumRegs];
	logic [HalfW-1:0] hw, hh;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign hw = regs_q[REG_VIEW][31:17];
	assign hh = regs_q[REG_VIEW][15:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRegs; i++) regs_q[i] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_X_AB, REG_X_CD, REG_Y_AB, REG_Y_CD, REG_W_AB, REG_W_CD:
					regs_q[cfg_index] <= cfg_data;
				REG_VIEW: regs_q[REG_VIEW] <= {32'd0, cfg_data[31:0]};
				default: ;
			endcase
		end
	end

	// stage 1: capture item
	logic v_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start && !busy;
	end
	always_ff @(posedge clk) begin
		px_s1 <= point_x;
		py_s1 <= point_y;
		pz_s1 <= point_z;
	end

	// stage 2: nine products
	logic v_s2;
	logic signed [63:0] prod_s2 [9];
	logic signed [31:0] d_s2 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			prod_s2[3*c]   <= $signed(regs_q[2*c][63:32]) * px_s1;
			prod_s2[3*c+1] <= $signed(regs_q[2*c][31:0]) * py_s1;
			prod_s2[3*c+2] <= $signed(regs_q[2*c+1][63:32]) * pz_s1;
			d_s2[c]        <= $signed(regs_q[2*c+1][31:0]);
		end
	end

	// stage 3: dot products, products floored to Q16.16
	logic v_s3;
	logic signed [SumW-1:0] sum_s3 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			sum_s3[c] <= SumW'($signed(prod_s2[3*c][63:16]))
				+ SumW'($signed(prod_s2[3*c+1][63:16]))
				+ SumW'($signed(prod_s2[3*c+2][63:16])) + SumW'(d_s2[c]);
		end
	end

	// stage 4: numerators, magnitudes and signs
	logic signed [MagW-1:0] nx, ny;
	logic v_s4, wz_s4, negx_s4, negy_s4, zx_s4, zy_s4;
	logic [MagW-1:0] ax_s4, ay_s4;
	logic [DivW-1:0] b_s4;
	assign nx = MagW'(sum_s3[0]) + MagW'(sum_s3[2]);
	assign ny = MagW'(sum_s3[1]) + MagW'(sum_s3[2]);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		wz_s4   <= sum_s3[2] == '0;
		b_s4    <= sum_s3[2][SumW-1] ? DivW'(-sum_s3[2]) : DivW'(sum_s3[2]);
		ax_s4   <= nx[MagW-1] ? MagW'(-nx) : MagW'(nx);
		ay_s4   <= ny[MagW-1] ? MagW'(-ny) : MagW'(ny);
		negx_s4 <= nx[MagW-1] != sum_s3[2][SumW-1];
		negy_s4 <= ny[MagW-1] != sum_s3[2][SumW-1];
		zx_s4   <= (nx == '0) || (hw == '0);
		zy_s4   <= (ny == '0) || (hh == '0);
	end

	// stage 5: partial products of magnitude times half size
	localparam int HiW = MagW - LoW;
	logic v_s5, wz_s5, negx_s5, negy_s5, zx_s5, zy_s5;
	logic [LoW+HalfW-1:0] xlo_s5, ylo_s5;
	logic [HiW+HalfW-1:0] xhi_s5, yhi_s5;
	logic [DivW-1:0] b_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		xlo_s5 <= ax_s4[LoW-1:0] * hw;
		xhi_s5 <= ax_s4[MagW-1:LoW] * hw;
		ylo_s5 <= ay_s4[LoW-1:0] * hh;
		yhi_s5 <= ay_s4[MagW-1:LoW] * hh;
		{wz_s5, negx_s5, negy_s5, zx_s5, zy_s5} <=
			{wz_s4, negx_s4, negy_s4, zx_s4, zy_s4};
		b_s5 <= b_s4;
	end

	// stage 6: full dividends
	logic v_s6, wz_s6, negx_s6, negy_s6, zx_s6, zy_s6;
	logic [NumW-1:0] numx_s6, numy_s6;
	logic [DivW-1:0] b_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		numx_s6 <= (NumW'(xhi_s5) << LoW) + NumW'(xlo_s5);
		numy_s6 <= (NumW'(yhi_s5) << LoW) + NumW'(ylo_s5);
		{wz_s6, negx_s6, negy_s6, zx_s6, zy_s6} <=
			{wz_s5, negx_s5, negy_s5, zx_s5, zy_s5};
		b_s6 <= b_s5;
	end

	// stage 7: saturation check, divider entry
	div_t div_s [QuoW+1];
	div_t ent;
	logic [NumW-1:0] bsat;
	assign bsat = NumW'(b_s6) << QuoW;
	always_comb begin
		ent.vld     = v_s6;
		ent.wzero   = wz_s6;
		ent.b       = b_s6;
		ent.cx.rem  = numx_s6;
		ent.cx.quo  = '0;
		ent.cx.neg  = negx_s6;
		ent.cx.zero = zx_s6;
		ent.cx.sat  = numx_s6 >= bsat;
		ent.cy.rem  = numy_s6;
		ent.cy.quo  = '0;
		ent.cy.neg  = negy_s6;
		ent.cy.zero = zy_s6;
		ent.cy.sat  = numy_s6 >= bsat;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_s[0] <= '0;
		else div_s[0] <= ent;
	end

	// restoring divider, one quotient bit per stage, most significant first
	for (genvar k = 0; k < QuoW; k++) begin : g_div
		localparam int Bit = QuoW - 1 - k;
		logic [NumW-1:0] dsh;
		logic            gex, gey;
		div_t            nxt;
		assign dsh = NumW'(div_s[k].b) << Bit;
		assign gex = div_s[k].cx.rem >= dsh;
		assign gey = div_s[k].cy.rem >= dsh;
		always_comb begin
			nxt = div_s[k];
			if (gex) begin
				nxt.cx.rem      = div_s[k].cx.rem - dsh;
				nxt.cx.quo[Bit] = 1'b1;
			end
			if (gey) begin
				nxt.cy.rem      = div_s[k].cy.rem - dsh;
				nxt.cy.quo[Bit] = 1'b1;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) div_s[k+1] <= '0;
			else div_s[k+1] <= nxt;
		end
	end

	// output: clamp and flag
	function automatic logic [16:0] finish(coord_t c);
		logic [16:0] r;
		if (c.zero)                r = '0;
		else if (c.sat)            r = c.neg ? 17'h10000 : 17'h1FFFF;
		else if (c.quo == '0)      r = '0;
		else if (c.neg)            r = 17'h10000;
		else if (c.quo > 17'hFFFF) r = 17'h1FFFF;
		else                       r = {1'b0, c.quo[15:0]};
		return r;
	endfunction

	logic [16:0] fx, fy;
	assign fx = finish(div_s[QuoW].cx);
	assign fy = finish(div_s[QuoW].cy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= div_s[QuoW].vld;
	end
	always_ff @(posedge clk) begin
		if (div_s[QuoW].wzero) begin
			screen_x <= '0;
			screen_y <= '0;
			invalid  <= 1'b1;
		end else begin
			screen_x <= fx[15:0];
			screen_y <= fy[15:0];
			invalid  <= fx[16] | fy[16];
		end
	end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for point_project_to_screen_top: projects random and corner-case points
// through a self-computed Q16.16 projection/viewport predictor and checks every result.
// Depends on pptos_pkg and the top-level RTL only.
module tb_top;
	import pptos_pkg::*;

	localparam int WatchLimit = 2000;
	localparam int Latency    = 25;

	typedef struct {
		logic [15:0] sx;
		logic [15:0] sy;
		logic        inv;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] point_x = '0;
	logic [31:0] point_y = '0;
	logic [31:0] point_z = '0;
	logic        done;
	logic [15:0] screen_x;
	logic [15:0] screen_y;
	logic        invalid;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	logic [63:0] coef[NumRegs];
	pixel_t      pending_pixels[$];
	bit          failed = 0;
	bit          steady = 0;
	int          quiet_cycles = 0;

	point_project_to_screen_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.done(done), .screen_x(screen_x), .screen_y(screen_y), .invalid(invalid),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint col_sum(logic [63:0] ab, logic [63:0] cd,
			longint px, longint py, longint pz);
		longint ca, cb, cc, cdd;
		ca  = longint'(signed'(ab[63:32]));
		cb  = longint'(signed'(ab[31:0]));
		cc  = longint'(signed'(cd[63:32]));
		cdd = longint'(signed'(cd[31:0]));
		return ((ca * px) >>> 16) + ((cb * py) >>> 16) + ((cc * pz) >>> 16) + cdd;
	endfunction

	function automatic logic [15:0] to_pixel(longint num, longint w,
			longint unsigned h, inout bit bad);
		longint n;
		bit neg;
		longint unsigned a, b, q, r, t;
		n   = num + w;
		neg = (n < 0) != (w < 0);
		a   = (n < 0) ? -n : n;
		b   = (w < 0) ? -w : w;
		if (h == 0 || a == 0)
			return 16'd0;
		q = a / b;
		r = a % b;
		if (q > 65535) begin
			bad = 1;
			return neg ? 16'd0 : 16'hFFFF;
		end
		t = q * h + (r * h) / b;
		if (t == 0)
			return 16'd0;
		if (neg) begin
			bad = 1;
			return 16'd0;
		end
		if (t > 65535) begin
			bad = 1;
			return 16'hFFFF;
		end
		return t[15:0];
	endfunction

	function automatic pixel_t project_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		longint px, py, pz, xs, ys, ws;
		bit bad;
		pixel_t p;
		px = longint'(signed'(x));
		py = longint'(signed'(y));
		pz = longint'(signed'(z));
		xs = col_sum(coef[REG_X_AB], coef[REG_X_CD], px, py, pz);
		ys = col_sum(coef[REG_Y_AB], coef[REG_Y_CD], px, py, pz);
		ws = col_sum(coef[REG_W_AB], coef[REG_W_CD], px, py, pz);
		bad = 0;
		if (ws == 0) begin
			p.sx = '0;
			p.sy = '0;
			p.inv = 1'b1;
			return p;
		end
		p.sx  = to_pixel(xs, ws, longint'(coef[REG_VIEW][31:17]), bad);
		p.sy  = to_pixel(ys, ws, longint'(coef[REG_VIEW][15:1]), bad);
		p.inv = bad;
		return p;
	endfunction

	function automatic bit idle_now();
		return !steady && ($urandom_range(0, 99) < 12);
	endfunction

	// Result checker
	always @(posedge clk) begin
		pixel_t e;
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d inv=%0b",
					$time, screen_x, screen_y, invalid);
				failed = 1;
			end else begin
				e = pending_pixels.pop_front();
				if (screen_x !== e.sx) begin
					$display("%0t: screen_x expected %0d actual %0d", $time, e.sx, screen_x);
					failed = 1;
				end
				if (screen_y !== e.sy) begin
					$display("%0t: screen_y expected %0d actual %0d", $time, e.sy, screen_y);
					failed = 1;
				end
				if (invalid !== e.inv) begin
					$display("%0t: invalid expected %0b actual %0b", $time, e.inv, invalid);
					failed = 1;
				end
			end
		end
	end

	// Watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchLimit) begin
			$display("%0t: watchdog expired", $time);
			$display("** point_project_to_screen_top: FAILED **");
			$finish;
		end
	end

	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		@(negedge clk);
		while (idle_now()) begin
			start = 1'b0;
			@(negedge clk);
		end
		start   = 1'b1;
		point_x = x;
		point_y = y;
		point_z = z;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		pending_pixels.push_back(project_point(x, y, z));
	endtask

	task automatic end_items();
		@(negedge clk);
		start = 1'b0;
	endtask

	// Hold until the pipeline is empty
	task automatic drain();
		end_items();
		wait (pending_pixels.size() == 0);
		repeat (Latency + 5) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		while (idle_now())
			@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		if (idx < NumRegs)
			coef[idx] = (idx == REG_VIEW) ? {32'd0, val[31:0]} : val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_matrix(logic [63:0] xab, logic [63:0] xcd, logic [63:0] yab,
			logic [63:0] ycd, logic [63:0] wab, logic [63:0] wcd, logic [63:0] view);
		write_reg(REG_X_AB, xab);
		write_reg(REG_X_CD, xcd);
		write_reg(REG_Y_AB, yab);
		write_reg(REG_Y_CD, ycd);
		write_reg(REG_W_AB, wab);
		write_reg(REG_W_CD, wcd);
		write_reg(REG_VIEW, view);
	endtask

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'sd0;
			2: return 32'h0001_0000;
			default: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
		endcase
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
			default: return 32'($signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000);
		endcase
	endfunction

	task automatic test_directed();
		// identity-like x/y, w = 1.0, 640x480
		load_matrix({32'h0001_0000, 32'h0}, 64'h0, {32'h0, 32'h0001_0000}, 64'h0,
			64'h0, {32'h0, 32'h0001_0000}, {32'h0, 16'd640, 16'd480});
		send_point(32'h0, 32'h0, 32'h0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_point(32'hFFFF_0000, 32'hFFFF_0000, 32'h0);
		send_point(32'hFFFF_FFFF, 32'hFFFF_F000, 32'h1);
		send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0);
		send_point(32'h0001_0000, 32'h0000_FFFF, 32'hFFFF_FFFF);
		drain();
		// w column zero
		write_reg(REG_W_CD, 64'h0);
		send_point(32'h1234_5678, 32'h0, 32'h0);
		send_point(32'h0, 32'h0, 32'h0);
		drain();
		// tiny w drives pixels past the top, huge viewport
		write_reg(REG_W_CD, {32'h0, 32'h0000_0001});
		write_reg(REG_VIEW, 64'hFFFF_FFFF_FFFF_FFFF);
		send_point(32'h0010_0000, 32'hFFF0_0000, 32'h0);
		send_point(32'h0, 32'h0, 32'h0);
		send_point(32'h0000_0001, 32'h0000_0001, 32'h0);
		drain();
		// zero viewport dimensions and an ignored register index
		write_reg(REG_W_CD, {32'h0, 32'h0001_0000});
		write_reg(REG_VIEW, {32'h0, 16'd0, 16'd1});
		write_reg(3'd7, 64'hDEAD_BEEF_0BAD_F00D);
		send_point(32'h0000_8000, 32'h0000_8000, 32'h0);
		send_point(32'hFFFE_0000, 32'h0002_0000, 32'h0);
		drain();
	endtask

	task automatic test_config_extremes();
		load_matrix('1, '1, '1, '1, '1, '1, '1);
		repeat (30) send_point(rand_coord(), rand_coord(), rand_coord());
		drain();
		load_matrix({32'h8000_0000, 32'h7FFF_FFFF}, {32'h8000_0000, 32'h7FFF_FFFF},
			{32'h7FFF_FFFF, 32'h8000_0000}, {32'h7FFF_FFFF, 32'h8000_0000},
			{32'h8000_0000, 32'h8000_0000}, {32'h7FFF_FFFF, 32'h8000_0000},
			{32'h0, 16'hFFFF, 16'hFFFF});
		repeat (30) send_point(rand_coord(), rand_coord(), rand_coord());
		drain();
	endtask

	task automatic test_random_views();
		for (int phase = 0; phase < 10; phase++) begin
			if (phase % 3 == 0)
				load_matrix({$urandom(), $urandom()}, {$urandom(), $urandom()},
					{$urandom(), $urandom()}, {$urandom(), $urandom()},
					{$urandom(), $urandom()}, {$urandom(), $urandom()},
					{$urandom(), $urandom()});
			else
				load_matrix({rand_coef(), rand_coef()}, {rand_coef(), rand_coef()},
					{rand_coef(), rand_coef()}, {rand_coef(), rand_coef()},
					{rand_coef(), rand_coef()}, {rand_coef(), 32'h0001_0000 + rand_coef()},
					{$urandom(), $urandom()});
			steady = (phase == 4);
			repeat (120) send_point(rand_coord(), rand_coord(), rand_coord());
			steady = 0;
			drain();
		end
	endtask

	initial begin
		for (int i = 0; i < NumRegs; i++)
			coef[i] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_config_extremes();
		test_random_views();
		if (!failed)
			$display("** point_project_to_screen_top: PASSED **");
		else
			$display("** point_project_to_screen_top: FAILED **");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/pptos_pkg.sv
hw/rtl/point_project_to_screen_top.sv
sim/tb_top.sv
